// ===== rtl/rtsenc_pkg.sv =====
`default_nettype none

package rtsenc_pkg;

  localparam int ColorW    = 8;
  localparam int BitTickW  = 8;
  localparam int TickW     = 15;
  localparam int LedCntW   = 9;
  localparam int PixIdxW   = 8;
  localparam int WordW     = 3 * ColorW;
  localparam int SymCntW   = $clog2(WordW);
  localparam int MaxLeds   = 256;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = TickW;
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegZeroHigh = 3'd0;
  localparam logic [CfgIdxW-1:0] RegZeroLow  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOneHigh  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOneLow   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLatch    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLedCount = 3'd5;

  localparam logic [BitTickW-1:0] ZeroHighRst = 8'd4;
  localparam logic [BitTickW-1:0] ZeroLowRst  = 8'd8;
  localparam logic [BitTickW-1:0] OneHighRst  = 8'd8;
  localparam logic [BitTickW-1:0] OneLowRst   = 8'd4;
  localparam logic [TickW-1:0]    LatchRst    = 15'd500;
  localparam logic [LedCntW-1:0]  LedCountRst = 9'd16;

  localparam logic [SymCntW-1:0] LastBit = SymCntW'(WordW - 1);

  typedef struct packed {
    logic [BitTickW-1:0] zero_high;
    logic [BitTickW-1:0] zero_low;
    logic [BitTickW-1:0] one_high;
    logic [BitTickW-1:0] one_low;
    logic [TickW-1:0]    latch;
    logic [LedCntW-1:0]  led_count;
  } cfg_t;

  // One queued pixel: GRB word, MSB first, and whether it closes the frame
  typedef struct packed {
    logic [WordW-1:0] grb;
    logic             ends;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_BITS  = 3'b010,
    ST_LATCH = 3'b100
  } back_st_e;

  // Rounded divide of an 8x8 product by 255, equal to (p + 127) / 255
  function automatic logic [ColorW-1:0] div255(input logic [2*ColorW-1:0] p);
    logic [2*ColorW:0] t;
    logic [2*ColorW:0] s;
    t = {1'b0, p} + (2*ColorW+1)'(128);
    s = t + (t >> ColorW);
    return s[2*ColorW-1:ColorW];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgba_to_ws2812_symbol_encoder.sv =====
// RGBA pixel to LED strip symbol encoder.
// Input channel (in_valid_i / in_stall_o): one pixel word per handshake. Color is
// premultiplied by alpha, pad sends black, bytes go out G, R, B, MSB first.
// Output channel (out_valid_o / out_stall_i): one symbol word per handshake, a high
// then a low duration for each bit, plus a latch word (frame_end_o) after the last
// pixel of a frame. last_o marks the final word caused by a pixel.
// A pixel passes the multiply stage, the alpha divide into a two-entry queue, the
// symbol serializer and the output register before its first symbol appears.
// The serializer issues one symbol word per cycle while the output is not stalled,
// one per bit of a pixel and a latch word for a pixel ending a frame, and sets the
// rate. Pixels are taken back to back until the queue and the multiply stage are
// full. Stall on the output holds the output register and the serializer; the queue
// then fills and in_stall_o rises. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must write it only while idle, which the block
// itself does not enforce. Reset loads default timings and clears the pixel position.
`default_nettype none

module rgba_to_ws2812_symbol_encoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rtsenc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rtsenc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [rtsenc_pkg::ColorW-1:0] red_i,
  input  wire logic [rtsenc_pkg::ColorW-1:0] green_i,
  input  wire logic [rtsenc_pkg::ColorW-1:0] blue_i,
  input  wire logic [rtsenc_pkg::ColorW-1:0] alpha_i,
  input  wire logic                          pad_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               first_level_o,
  output logic [rtsenc_pkg::TickW-1:0]       first_ticks_o,
  output logic                               second_level_o,
  output logic [rtsenc_pkg::TickW-1:0]       second_ticks_o,
  output logic                               frame_end_o,
  output logic                               last_o
);
  import rtsenc_pkg::*;

  cfg_t  cfg_q;
  logic  push, full, pop, fifo_valid;
  item_t push_item, pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_high <= ZeroHighRst;
      cfg_q.zero_low  <= ZeroLowRst;
      cfg_q.one_high  <= OneHighRst;
      cfg_q.one_low   <= OneLowRst;
      cfg_q.latch     <= LatchRst;
      cfg_q.led_count <= LedCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegZeroHigh: cfg_q.zero_high <= cfg_wdata_i[BitTickW-1:0];
        RegZeroLow:  cfg_q.zero_low  <= cfg_wdata_i[BitTickW-1:0];
        RegOneHigh:  cfg_q.one_high  <= cfg_wdata_i[BitTickW-1:0];
        RegOneLow:   cfg_q.one_low   <= cfg_wdata_i[BitTickW-1:0];
        RegLatch:    cfg_q.latch     <= cfg_wdata_i[TickW-1:0];
        RegLedCount: cfg_q.led_count <= cfg_wdata_i[LedCntW-1:0];
        default:     cfg_q           <= cfg_q;
      endcase
    end
  end

  rtsenc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .alpha_i     (alpha_i),
    .pad_i       (pad_i),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (full)
  );

  rtsenc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .pop_item_o  (pop_item)
  );

  rtsenc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .valid_i        (fifo_valid),
    .item_i         (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .first_level_o  (first_level_o),
    .first_ticks_o  (first_ticks_o),
    .second_level_o (second_level_o),
    .second_ticks_o (second_ticks_o),
    .frame_end_o    (frame_end_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/rtsenc_front.sv =====
`default_nettype none

module rtsenc_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rtsenc_pkg::cfg_t            cfg_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [rtsenc_pkg::ColorW-1:0] red_i,
  input  wire logic [rtsenc_pkg::ColorW-1:0] green_i,
  input  wire logic [rtsenc_pkg::ColorW-1:0] blue_i,
  input  wire logic [rtsenc_pkg::ColorW-1:0] alpha_i,
  input  wire logic                        pad_i,
  output logic                             push_o,
  output rtsenc_pkg::item_t                push_item_o,
  input  wire logic                        full_i
);
  import rtsenc_pkg::*;

  logic                  s1_valid_q, s1_valid_d;
  logic [2*ColorW-1:0]   prod_r_q, prod_g_q, prod_b_q;
  logic                  ends_q;
  logic [PixIdxW-1:0]    idx_q, idx_d;
  logic [LedCntW-1:0]    eff_count;
  logic [LedCntW-1:0]    idx_next;
  logic                  ends;
  logic                  accept;
  logic                  advance;
  logic [ColorW-1:0]     alpha_g;

  // Clamp the LED count to 1..MaxLeds
  always_comb begin
    priority if (cfg_i.led_count == '0) begin
      eff_count = LedCntW'(1);
    end else if (cfg_i.led_count > LedCntW'(MaxLeds)) begin
      eff_count = LedCntW'(MaxLeds);
    end else begin
      eff_count = cfg_i.led_count;
    end
  end

  assign idx_next = {1'b0, idx_q} + LedCntW'(1);
  assign ends     = idx_next >= eff_count;

  assign advance    = !s1_valid_q || !full_i;
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;
  assign alpha_g    = pad_i ? '0 : alpha_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (advance) begin
      s1_valid_d = in_valid_i;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      idx_d = ends ? '0 : idx_next[PixIdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_r_q <= red_i * alpha_g;
      prod_g_q <= green_i * alpha_g;
      prod_b_q <= blue_i * alpha_g;
      ends_q   <= ends;
    end
  end

  assign push_o           = s1_valid_q && !full_i;
  assign push_item_o.grb  = {div255(prod_g_q), div255(prod_r_q), div255(prod_b_q)};
  assign push_item_o.ends = ends_q;

endmodule

`default_nettype wire

// ===== rtl/rtsenc_fifo.sv =====
`default_nettype none

module rtsenc_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire rtsenc_pkg::item_t push_item_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output rtsenc_pkg::item_t      pop_item_o
);
  import rtsenc_pkg::*;

  item_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]  cnt_q;
  logic                 do_push, do_pop;

  assign full_o     = cnt_q == FifoCntW'(FifoDepth);
  assign valid_o    = cnt_q != '0;
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoPtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + FifoCntW'(1);
        2'b01:   cnt_q <= cnt_q - FifoCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rtsenc_back.sv =====
`default_nettype none

module rtsenc_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rtsenc_pkg::cfg_t            cfg_i,
  input  wire logic                        valid_i,
  input  wire rtsenc_pkg::item_t           item_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             first_level_o,
  output logic [rtsenc_pkg::TickW-1:0]     first_ticks_o,
  output logic                             second_level_o,
  output logic [rtsenc_pkg::TickW-1:0]     second_ticks_o,
  output logic                             frame_end_o,
  output logic                             last_o
);
  import rtsenc_pkg::*;

  back_st_e            st_q, st_d;
  logic [WordW-1:0]    word_q, word_d;
  logic                ends_q, ends_d;
  logic [SymCntW-1:0]  cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic                fetch;
  logic                bit_v;
  logic [BitTickW-1:0] hi_ticks, lo_ticks;
  logic [TickW-1:0]    half_ticks;

  assign out_load   = (st_q != ST_IDLE) && (!out_valid_q || !out_stall_i);
  assign bit_v      = word_q[WordW-1];
  assign hi_ticks   = bit_v ? cfg_i.one_high : cfg_i.zero_high;
  assign lo_ticks   = bit_v ? cfg_i.one_low : cfg_i.zero_low;
  assign half_ticks = cfg_i.latch >> 1;

  // Fetch the next word when idle or when the current one issues its final symbol
  always_comb begin
    unique case (st_q)
      ST_IDLE:  fetch = 1'b1;
      ST_BITS:  fetch = out_load && (cnt_q == LastBit) && !ends_q;
      ST_LATCH: fetch = out_load;
      default:  fetch = 1'b1;
    endcase
  end

  assign pop_o = fetch && valid_i;

  always_comb begin
    st_d   = st_q;
    word_d = word_q;
    ends_d = ends_q;
    cnt_d  = cnt_q;
    if (fetch) begin
      if (valid_i) begin
        st_d   = ST_BITS;
        word_d = item_i.grb;
        ends_d = item_i.ends;
        cnt_d  = '0;
      end else begin
        st_d = ST_IDLE;
      end
    end else if (st_q == ST_BITS && out_load) begin
      word_d = word_q << 1;
      cnt_d  = cnt_q + SymCntW'(1);
      if (cnt_q == LastBit) begin
        st_d = ST_LATCH;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    ends_q <= ends_d;
    if (out_load) begin
      if (st_q == ST_LATCH) begin
        first_level_o  <= 1'b0;
        first_ticks_o  <= half_ticks;
        second_level_o <= 1'b0;
        second_ticks_o <= half_ticks;
        frame_end_o    <= 1'b1;
        last_o         <= 1'b1;
      end else begin
        first_level_o  <= 1'b1;
        first_ticks_o  <= TickW'(hi_ticks);
        second_level_o <= 1'b0;
        second_ticks_o <= TickW'(lo_ticks);
        frame_end_o    <= 1'b0;
        last_o         <= (cnt_q == LastBit) && !ends_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_fe_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && frame_end_o |-> last_o)
    else $error("latch word without last");

  a_latch_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_LATCH |-> ends_q && $past(st_q) == ST_BITS || $past(st_q) == ST_LATCH)
    else $error("latch state not entered from bit state");

  a_bit_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !frame_end_o |-> first_level_o && !second_level_o)
    else $error("bit word with wrong levels");

endmodule

`default_nettype wire

// ===== sim/rtsenc_symbol_checker.sv =====
`default_nettype none

module rtsenc_symbol_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rtsenc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rtsenc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_stall_i,
  input  wire logic [rtsenc_pkg::ColorW-1:0]   red_i,
  input  wire logic [rtsenc_pkg::ColorW-1:0]   green_i,
  input  wire logic [rtsenc_pkg::ColorW-1:0]   blue_i,
  input  wire logic [rtsenc_pkg::ColorW-1:0]   alpha_i,
  input  wire logic                            pad_i,
  input  wire logic                            out_valid_i,
  input  wire logic                            out_stall_i,
  input  wire logic                            first_level_i,
  input  wire logic [rtsenc_pkg::TickW-1:0]    first_ticks_i,
  input  wire logic                            second_level_i,
  input  wire logic [rtsenc_pkg::TickW-1:0]    second_ticks_i,
  input  wire logic                            frame_end_i,
  input  wire logic                            last_i,
  output int                                   pending_o,
  output int                                   errors_o
);
  import rtsenc_pkg::*;

  typedef struct packed {
    logic             first_level;
    logic [TickW-1:0] first_ticks;
    logic             second_level;
    logic [TickW-1:0] second_ticks;
    logic             frame_end;
    logic             last;
  } symbol_t;

  logic [BitTickW-1:0] zero_high, zero_low, one_high, one_low;
  logic [TickW-1:0]    latch_len;
  logic [LedCntW-1:0]  strip_len;
  logic [PixIdxW-1:0]  pix_pos;
  symbol_t             exp_symbols[$];
  symbol_t             got, want;
  int                  err_count = 0;

  assign errors_o = err_count;

  function automatic logic [ColorW-1:0] scale_by_alpha(input logic [ColorW-1:0] c,
                                                       input logic [ColorW-1:0] a);
    int unsigned p;
    p = int'(c) * int'(a) + 127;
    return ColorW'(p / 255);
  endfunction

  // Queue the 24 bit symbols of one pixel and the latch symbol if it closes the frame
  task automatic encode_pixel();
    logic [ColorW-1:0]  rc, gc, bc;
    logic [WordW-1:0]   grb;
    logic [LedCntW-1:0] frame_len;
    logic               closes, b;
    symbol_t            s;
    rc = '0;
    gc = '0;
    bc = '0;
    if (!pad_i) begin
      rc = scale_by_alpha(red_i, alpha_i);
      gc = scale_by_alpha(green_i, alpha_i);
      bc = scale_by_alpha(blue_i, alpha_i);
    end
    grb = {gc, rc, bc};
    frame_len = strip_len;
    if (frame_len == '0) frame_len = LedCntW'(1);
    if (frame_len > LedCntW'(MaxLeds)) frame_len = LedCntW'(MaxLeds);
    closes = ({1'b0, pix_pos} + LedCntW'(1)) >= frame_len;
    for (int k = 0; k < WordW; k++) begin
      b = grb[WordW-1-k];
      s.first_level  = 1'b1;
      s.first_ticks  = TickW'(b ? one_high : zero_high);
      s.second_level = 1'b0;
      s.second_ticks = TickW'(b ? one_low : zero_low);
      s.frame_end    = 1'b0;
      s.last         = !closes && (k == WordW - 1);
      exp_symbols.push_back(s);
    end
    if (closes) begin
      s.first_level  = 1'b0;
      s.first_ticks  = latch_len >> 1;
      s.second_level = 1'b0;
      s.second_ticks = latch_len >> 1;
      s.frame_end    = 1'b1;
      s.last         = 1'b1;
      exp_symbols.push_back(s);
      pix_pos = '0;
    end else begin
      pix_pos = pix_pos + PixIdxW'(1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_high = ZeroHighRst;
      zero_low  = ZeroLowRst;
      one_high  = OneHighRst;
      one_low   = OneLowRst;
      latch_len = LatchRst;
      strip_len = LedCountRst;
      pix_pos   = '0;
      exp_symbols.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegZeroHigh: zero_high = cfg_wdata_i[BitTickW-1:0];
          RegZeroLow:  zero_low  = cfg_wdata_i[BitTickW-1:0];
          RegOneHigh:  one_high  = cfg_wdata_i[BitTickW-1:0];
          RegOneLow:   one_low   = cfg_wdata_i[BitTickW-1:0];
          RegLatch:    latch_len = cfg_wdata_i[TickW-1:0];
          RegLedCount: strip_len = cfg_wdata_i[LedCntW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) encode_pixel();
      if (out_valid_i && !out_stall_i) begin
        got = '{first_level_i, first_ticks_i, second_level_i, second_ticks_i,
                frame_end_i, last_i};
        if (exp_symbols.size() == 0) begin
          err_count++;
          $display("%0t: unexpected symbol word: lvl %0b/%0b ticks %0d/%0d fe %0b last %0b",
                   $time, got.first_level, got.second_level, got.first_ticks,
                   got.second_ticks, got.frame_end, got.last);
        end else begin
          want = exp_symbols.pop_front();
          if (got.first_level !== want.first_level || got.first_ticks !== want.first_ticks ||
              got.second_level !== want.second_level ||
              got.second_ticks !== want.second_ticks ||
              got.frame_end !== want.frame_end || got.last !== want.last) begin
            err_count++;
            $display("%0t: symbol mismatch: expected lvl %0b/%0b ticks %0d/%0d fe %0b ",
                     $time, want.first_level, want.second_level, want.first_ticks,
                     want.second_ticks, want.frame_end,
                     "last %0b, actual lvl %0b/%0b ticks %0d/%0d fe %0b last %0b",
                     want.last, got.first_level, got.second_level, got.first_ticks,
                     got.second_ticks, got.frame_end, got.last);
          end
        end
      end
      pending_o <= exp_symbols.size();
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_rgba_to_ws2812_symbol_encoder.sv =====
`default_nettype none

module tb_rgba_to_ws2812_symbol_encoder;
  import rtsenc_pkg::*;

  localparam int StuckLimit = 5000;
  // Indexes past the register file; writes there must do nothing
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [ColorW-1:0]   red_i       = '0;
  logic [ColorW-1:0]   green_i     = '0;
  logic [ColorW-1:0]   blue_i      = '0;
  logic [ColorW-1:0]   alpha_i     = '0;
  logic                pad_i       = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                first_level_o;
  logic [TickW-1:0]    first_ticks_o;
  logic                second_level_o;
  logic [TickW-1:0]    second_ticks_o;
  logic                frame_end_o;
  logic                last_o;

  int pending_words;
  int fail_count;
  int send_idle_pct = 14;
  int recv_stall_pct = 84;
  int stuck_cycles = 0;

  rgba_to_ws2812_symbol_encoder u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .red_i, .green_i, .blue_i, .alpha_i, .pad_i,
    .out_valid_o, .out_stall_i, .first_level_o, .first_ticks_o, .second_level_o,
    .second_ticks_o, .frame_end_o, .last_o
  );

  rtsenc_symbol_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .red_i, .green_i, .blue_i, .alpha_i, .pad_i,
    .out_valid_i(out_valid_o), .out_stall_i, .first_level_i(first_level_o),
    .first_ticks_i(first_ticks_o), .second_level_i(second_level_o),
    .second_ticks_i(second_ticks_o), .frame_end_i(frame_end_o), .last_i(last_o),
    .pending_o(pending_words), .errors_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one pixel word; valid stays high afterwards unless a gap follows
  task automatic send_pixel(input logic [ColorW-1:0] r, input logic [ColorW-1:0] g,
                            input logic [ColorW-1:0] b, input logic [ColorW-1:0] a,
                            input logic p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    alpha_i    <= a;
    pad_i      <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct,
                           input int zh, input int zl,
                           input int oh, input int ol,
                           input int lt, input int lc,
                           input int n_pixels, input bit poke_spare);
    int sel;
    logic [ColorW-1:0] a;
    drain();
    write_reg(RegZeroHigh, CfgDataW'(zh));
    write_reg(RegZeroLow, CfgDataW'(zl));
    write_reg(RegOneHigh, CfgDataW'(oh));
    write_reg(RegOneLow, CfgDataW'(ol));
    write_reg(RegLatch, CfgDataW'(lt));
    write_reg(RegLedCount, CfgDataW'(lc));
    if (poke_spare) begin
      write_reg(RegSpareLo, CfgDataW'($urandom));
      write_reg(RegSpareHi, CfgDataW'($urandom));
    end
    cfg_we_i <= 1'b0;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n_pixels; i++) begin
      sel = $urandom_range(9);
      a = (sel < 3) ? 8'd255 : (sel == 3) ? 8'd0 : ColorW'($urandom_range(255));
      send_pixel(ColorW'($urandom_range(255)), ColorW'($urandom_range(255)),
                 ColorW'($urandom_range(255)), a, $urandom_range(9) == 0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels at reset timings; the frame of 16 closes inside this run
    send_pixel(8'h00, 8'h00, 8'h00, 8'hff, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 8'h00, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 8'h01, 1'b0);
    send_pixel(8'h01, 8'h01, 8'h01, 8'h80, 1'b0);
    send_pixel(8'haa, 8'h55, 8'hf0, 8'hff, 1'b0);
    send_pixel(8'h55, 8'haa, 8'h0f, 8'hff, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    send_pixel(8'h80, 8'h40, 8'h20, 8'h7f, 1'b0);
    send_pixel(8'hc8, 8'h64, 8'h32, 8'hfe, 1'b0);
    send_pixel(8'h01, 8'hfe, 8'h7f, 8'hff, 1'b0);
    for (int k = 0; k < 6; k++)
      send_pixel(8'h01 << k, 8'h80 >> k, 8'h03 << k, 8'hff, k[0]);

    // Sender mostly busy, receiver stalls often
    run_phase(14, 84, 0, 0, 255, 255, 0, 0, 40, 1'b1);
    run_phase(14, 84, 255, 1, 1, 255, 1, 300, 45, 1'b0);
    run_phase(14, 84, $urandom_range(1, 255), $urandom_range(1, 255),
              $urandom_range(1, 255), $urandom_range(1, 255),
              $urandom_range(2, 32767), $urandom_range(1, 24), 45, 1'b0);
    // Sender idles often, receiver rarely stalls
    run_phase(84, 14, 1, 1, 1, 1, 32767, 1, 45, 1'b0);
    run_phase(84, 14, 255, 255, 255, 255, 2, 256, 45, 1'b1);
    run_phase(84, 14, $urandom_range(1, 255), $urandom_range(1, 255),
              $urandom_range(1, 255), $urandom_range(1, 255),
              $urandom_range(2, 32767), $urandom_range(1, 24), 45, 1'b0);
    // No idling on either side; upper write bits must be dropped
    run_phase(0, 0, $urandom_range(0, 32767), $urandom_range(0, 32767),
              $urandom_range(0, 32767), $urandom_range(0, 32767),
              $urandom_range(0, 32767), $urandom_range(0, 32767), 45, 1'b1);
    run_phase(0, 0, $urandom_range(1, 255), $urandom_range(1, 255),
              $urandom_range(1, 255), $urandom_range(1, 255),
              $urandom_range(2, 32767), $urandom_range(1, 24), 50, 1'b0);
    run_phase(0, 0, 4, 8, 8, 4, 500, 16, 50, 1'b0);

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
